>>> rtl/heat_ftcs_stencil_step_assert.svh
// Assertion macros for the FTCS stencil block.
// Needs clk and rst_n in the scope of the module that expands them.
`ifndef HEAT_FTCS_STENCIL_STEP_ASSERT_SVH
`define HEAT_FTCS_STENCIL_STEP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hfs_pkg.sv
// Shared constants, register codes and helpers for the FTCS stencil block.
// No dependencies.
`timescale 1ns / 1ps

package hfs_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int MAX_COLS = 1024;
    localparam int TEMP_W   = 32;
    localparam int COEF_W   = 16;
    localparam int FRAC_W   = 16;
    localparam int CFG_W    = 32;
    localparam int MASK_W   = 4;

    // Padded positions run up to MAX+1
    localparam int DIM_W    = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 2);
    localparam int LINE_LEN = MAX_COLS + 2;
    localparam int COL_AW   = $clog2(LINE_LEN);

    localparam int LAP_W    = TEMP_W + 2;
    localparam int HI_W     = LAP_W - FRAC_W;
    localparam int PROD_W   = COEF_W + 1 + HI_W;
    localparam int FL_W     = COEF_W + FRAC_W;
    localparam int FSUM_W   = FL_W + 2;
    localparam int FHI_W    = FSUM_W - FRAC_W;
    localparam int SUM_W    = PROD_W + 2;

    localparam logic [FSUM_W-1:0] ROUND_HALF = FSUM_W'(1) << (FRAC_W - 1);

    localparam logic [DIM_W-1:0] ROWS_MAX = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0] COLS_MAX = DIM_W'(MAX_COLS);

    // edge_mask bits
    localparam int EDGE_SOUTH = 0;
    localparam int EDGE_NORTH = 1;
    localparam int EDGE_WEST  = 2;
    localparam int EDGE_EAST  = 3;

    typedef enum logic [2:0] {
        REG_COEF_X    = 3'd0,
        REG_COEF_Y    = 3'd1,
        REG_BND_TEMP  = 3'd2,
        REG_EDGE_MASK = 3'd3,
        REG_ROWS      = 3'd4,
        REG_COLS      = 3'd5
    } hfs_reg_t;

    localparam int REG_IDX_W = $bits(hfs_reg_t);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] res;
        if (v == '0)
            res = DIM_W'(1);
        else if (v > maxv)
            res = maxv;
        else
            res = v;
        return res;
    endfunction

    function automatic logic signed [LAP_W-1:0] ext_lap(input logic signed [TEMP_W-1:0] x);
        return {{(LAP_W - TEMP_W){x[TEMP_W-1]}}, x};
    endfunction

endpackage

>>> rtl/hfs_in_if.sv
// Input stream channel: one padded-tile temperature per word.
// Depends on hfs_pkg.
`timescale 1ns / 1ps

interface hfs_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [hfs_pkg::TEMP_W-1:0]    temp_in;

    modport source (output valid, output temp_in, input ready);
    modport sink   (input valid, input temp_in, output ready);
endinterface

>>> rtl/hfs_out_if.sv
// Output stream channel: one updated interior cell per word.
// Depends on hfs_pkg.
`timescale 1ns / 1ps

interface hfs_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [hfs_pkg::TEMP_W-1:0]    temp_out;
    logic        [hfs_pkg::DIM_W-1:0]     row_index;
    logic        [hfs_pkg::DIM_W-1:0]     col_index;
    logic                                 tile_done;

    modport source (output valid, output temp_out, output row_index, output col_index,
                    output tile_done, input ready);
    modport sink   (input valid, input temp_out, input row_index, input col_index,
                    input tile_done, output ready);
endinterface

>>> rtl/heat_ftcs_stencil_step.sv
// FTCS five-point heat stencil over a ghost-padded tile; uses hfs_pkg, hfs_in_if, hfs_out_if.
// Pipeline from input accept to result valid: line read, Laplacian, multiply, sum registers.
// One word per cycle unless the output stalls; two single-port-read line banks at the column.
// Reset clears config (coefs 0, boundary 0, mask 0xF, 1024 x 1024), counters and valid bits.
// Line buffers are not cleared; each read feeding a result follows a write of the same tile.
`timescale 1ns / 1ps
`include "heat_ftcs_stencil_step_assert.svh"

module heat_ftcs_stencil_step (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hfs_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [hfs_pkg::CFG_W-1:0]         cfg_data,
    hfs_in_if.sink                            samples,
    hfs_out_if.source                         updates
);

    // ---------------- configuration ----------------
    logic        [hfs_pkg::COEF_W-1:0]  coef_x_reg;
    logic        [hfs_pkg::COEF_W-1:0]  coef_y_reg;
    logic signed [hfs_pkg::TEMP_W-1:0]  bnd_temp_reg;
    logic        [hfs_pkg::MASK_W-1:0]  edge_mask_reg;
    logic        [hfs_pkg::DIM_W-1:0]   rows_reg;
    logic        [hfs_pkg::DIM_W-1:0]   cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x_reg    <= '0;
            coef_y_reg    <= '0;
            bnd_temp_reg  <= '0;
            edge_mask_reg <= '1;
            rows_reg      <= hfs_pkg::ROWS_MAX;
            cols_reg      <= hfs_pkg::COLS_MAX;
        end
        else if (cfg_we)
        begin
            unique case (hfs_pkg::hfs_reg_t'(cfg_index))
                hfs_pkg::REG_COEF_X:    coef_x_reg    <= cfg_data[hfs_pkg::COEF_W-1:0];
                hfs_pkg::REG_COEF_Y:    coef_y_reg    <= cfg_data[hfs_pkg::COEF_W-1:0];
                hfs_pkg::REG_BND_TEMP:  bnd_temp_reg  <= cfg_data[hfs_pkg::TEMP_W-1:0];
                hfs_pkg::REG_EDGE_MASK: edge_mask_reg <= cfg_data[hfs_pkg::MASK_W-1:0];
                hfs_pkg::REG_ROWS:      rows_reg      <= cfg_data[hfs_pkg::DIM_W-1:0];
                hfs_pkg::REG_COLS:      cols_reg      <= cfg_data[hfs_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_prod_reg, s2_prod_reg, s3_prod_reg;
    logic out_free, rdy1, rdy2, rdy3, in_fire, s1_move;

    assign out_free      = !out_valid_reg || updates.ready;
    assign rdy3          = !s3_valid_reg || !s3_prod_reg || out_free;
    assign rdy2          = !s2_valid_reg || rdy3;
    assign rdy1          = !s1_valid_reg || rdy2;
    assign samples.ready = rdy1;
    assign in_fire       = samples.valid && rdy1;
    assign s1_move       = s1_valid_reg && rdy2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_valid_reg <= samples.valid;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
            if (out_free)
                out_valid_reg <= s3_valid_reg && s3_prod_reg;
        end
    end

    // ---------------- stage 0: position, ghost substitution ----------------
    logic [hfs_pkg::DIM_W-1:0] row_cnt_reg, col_cnt_reg;
    logic [hfs_pkg::DIM_W-1:0] row_cnt_next, col_cnt_next;
    logic [hfs_pkg::DIM_W-1:0] rows_eff, cols_eff, row_last, col_last, cur_row, cur_col;
    logic signed [hfs_pkg::TEMP_W-1:0] cur_val;
    logic is_ghost, cur_prod, cur_done;

    always_comb
    begin
        rows_eff = hfs_pkg::clamp_dim(rows_reg, hfs_pkg::ROWS_MAX);
        cols_eff = hfs_pkg::clamp_dim(cols_reg, hfs_pkg::COLS_MAX);
        row_last = rows_eff + hfs_pkg::DIM_W'(1);
        col_last = cols_eff + hfs_pkg::DIM_W'(1);
        cur_row  = (row_cnt_reg > row_last) ? row_last : row_cnt_reg;
        cur_col  = (col_cnt_reg > col_last) ? col_last : col_cnt_reg;

        is_ghost = ((cur_row == '0)      && edge_mask_reg[hfs_pkg::EDGE_SOUTH]) ||
                   ((cur_row == row_last) && edge_mask_reg[hfs_pkg::EDGE_NORTH]) ||
                   ((cur_col == '0)      && edge_mask_reg[hfs_pkg::EDGE_WEST])  ||
                   ((cur_col == col_last) && edge_mask_reg[hfs_pkg::EDGE_EAST]);
        cur_val  = is_ghost ? bnd_temp_reg : samples.temp_in;

        cur_prod = (cur_row >= hfs_pkg::DIM_W'(2)) && (cur_col >= hfs_pkg::DIM_W'(2));
        cur_done = (cur_row == row_last) && (cur_col == col_last);

        // wrap at the last padded column, and the tile at the last padded row
        if (cur_col >= col_last)
        begin
            col_cnt_next = '0;
            row_cnt_next = (cur_row >= row_last) ? '0 : cur_row + hfs_pkg::DIM_W'(1);
        end
        else
        begin
            col_cnt_next = cur_col + hfs_pkg::DIM_W'(1);
            row_cnt_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else if (in_fire)
        begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
        end
    end

    // ---------------- line buffers: bank per row parity ----------------
    logic signed [hfs_pkg::TEMP_W-1:0] line_even_mem [hfs_pkg::LINE_LEN];
    logic signed [hfs_pkg::TEMP_W-1:0] line_odd_mem  [hfs_pkg::LINE_LEN];
    logic signed [hfs_pkg::TEMP_W-1:0] rd_even_reg, rd_odd_reg;
    logic [hfs_pkg::COL_AW-1:0] line_addr;

    assign line_addr = cur_col[hfs_pkg::COL_AW-1:0];

    // read-first: own-parity bank gives the word two rows back, the other bank one row back
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_even_reg <= line_even_mem[line_addr];
            if (!cur_row[0])
                line_even_mem[line_addr] <= cur_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_odd_reg <= line_odd_mem[line_addr];
            if (cur_row[0])
                line_odd_mem[line_addr] <= cur_val;
        end
    end

    // ---------------- stage 1 ----------------
    logic signed [hfs_pkg::TEMP_W-1:0] s1_val_reg;
    logic                              s1_odd_reg, s1_done_reg;
    logic [hfs_pkg::DIM_W-1:0]         s1_row_reg, s1_col_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_val_reg  <= cur_val;
            s1_odd_reg  <= cur_row[0];
            s1_prod_reg <= cur_prod;
            s1_done_reg <= cur_done;
            s1_row_reg  <= cur_row - hfs_pkg::DIM_W'(1);
            s1_col_reg  <= cur_col - hfs_pkg::DIM_W'(1);
        end
    end

    // ---------------- window and Laplacians ----------------
    logic signed [hfs_pkg::TEMP_W-1:0] win_south_reg, win_center_reg, win_north_reg;
    logic signed [hfs_pkg::TEMP_W-1:0] win_west_reg;
    logic signed [hfs_pkg::TEMP_W-1:0] col_south, col_mid;
    logic signed [hfs_pkg::LAP_W-1:0]  lap_x_next, lap_y_next, two_c;

    always_comb
    begin
        col_south  = s1_odd_reg ? rd_odd_reg  : rd_even_reg;
        col_mid    = s1_odd_reg ? rd_even_reg : rd_odd_reg;
        two_c      = hfs_pkg::ext_lap(win_center_reg) + hfs_pkg::ext_lap(win_center_reg);
        lap_x_next = hfs_pkg::ext_lap(win_north_reg) + hfs_pkg::ext_lap(win_south_reg) - two_c;
        lap_y_next = hfs_pkg::ext_lap(col_mid) + hfs_pkg::ext_lap(win_west_reg) - two_c;
    end

    logic signed [hfs_pkg::TEMP_W-1:0] s2_c_reg;
    logic signed [hfs_pkg::LAP_W-1:0]  s2_lap_x_reg, s2_lap_y_reg;
    logic                              s2_done_reg;
    logic [hfs_pkg::DIM_W-1:0]         s2_row_reg, s2_col_reg;

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            // advance the window one column
            win_west_reg   <= win_center_reg;
            win_south_reg  <= col_south;
            win_center_reg <= col_mid;
            win_north_reg  <= s1_val_reg;

            s2_c_reg       <= win_center_reg;
            s2_lap_x_reg   <= lap_x_next;
            s2_lap_y_reg   <= lap_y_next;
            s2_prod_reg    <= s1_prod_reg;
            s2_done_reg    <= s1_done_reg;
            s2_row_reg     <= s1_row_reg;
            s2_col_reg     <= s1_col_reg;
        end
    end

    // ---------------- stage 3: coefficient products ----------------
    logic signed [hfs_pkg::HI_W-1:0]   x_hi, y_hi;
    logic        [hfs_pkg::FRAC_W-1:0] x_lo, y_lo;
    logic signed [hfs_pkg::PROD_W-1:0] px_next, py_next;
    logic        [hfs_pkg::FL_W-1:0]   fx_next, fy_next;

    always_comb
    begin
        x_hi    = s2_lap_x_reg[hfs_pkg::LAP_W-1:hfs_pkg::FRAC_W];
        y_hi    = s2_lap_y_reg[hfs_pkg::LAP_W-1:hfs_pkg::FRAC_W];
        x_lo    = s2_lap_x_reg[hfs_pkg::FRAC_W-1:0];
        y_lo    = s2_lap_y_reg[hfs_pkg::FRAC_W-1:0];
        px_next = $signed({1'b0, coef_x_reg}) * x_hi;
        py_next = $signed({1'b0, coef_y_reg}) * y_hi;
        fx_next = coef_x_reg * x_lo;
        fy_next = coef_y_reg * y_lo;
    end

    logic signed [hfs_pkg::TEMP_W-1:0] s3_c_reg;
    logic signed [hfs_pkg::PROD_W-1:0] s3_px_reg, s3_py_reg;
    logic        [hfs_pkg::FL_W-1:0]   s3_fx_reg, s3_fy_reg;
    logic                              s3_done_reg;
    logic [hfs_pkg::DIM_W-1:0]         s3_row_reg, s3_col_reg;

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && rdy3)
        begin
            s3_c_reg    <= s2_c_reg;
            s3_px_reg   <= px_next;
            s3_py_reg   <= py_next;
            s3_fx_reg   <= fx_next;
            s3_fy_reg   <= fy_next;
            s3_prod_reg <= s2_prod_reg;
            s3_done_reg <= s2_done_reg;
            s3_row_reg  <= s2_row_reg;
            s3_col_reg  <= s2_col_reg;
        end
    end

    // ---------------- output: sum, round, saturate ----------------
    logic        [hfs_pkg::FSUM_W-1:0] frac_sum;
    logic signed [hfs_pkg::SUM_W-1:0]  total;
    logic signed [hfs_pkg::TEMP_W-1:0] temp_next;
    logic                              in_range;

    always_comb
    begin
        frac_sum = {2'b00, s3_fx_reg} + {2'b00, s3_fy_reg} + hfs_pkg::ROUND_HALF;
        total    = $signed({{(hfs_pkg::SUM_W - hfs_pkg::TEMP_W){s3_c_reg[hfs_pkg::TEMP_W-1]}},
                             s3_c_reg})
                 + $signed({{(hfs_pkg::SUM_W - hfs_pkg::PROD_W){s3_px_reg[hfs_pkg::PROD_W-1]}},
                             s3_px_reg})
                 + $signed({{(hfs_pkg::SUM_W - hfs_pkg::PROD_W){s3_py_reg[hfs_pkg::PROD_W-1]}},
                             s3_py_reg})
                 + $signed({{(hfs_pkg::SUM_W - hfs_pkg::FHI_W){1'b0}},
                             frac_sum[hfs_pkg::FSUM_W-1:hfs_pkg::FRAC_W]});
        // in range when all bits above the result's sign agree with it
        in_range = (total[hfs_pkg::SUM_W-1:hfs_pkg::TEMP_W-1] == '0) ||
                   (total[hfs_pkg::SUM_W-1:hfs_pkg::TEMP_W-1] == '1);
        if (in_range)
            temp_next = total[hfs_pkg::TEMP_W-1:0];
        else if (total[hfs_pkg::SUM_W-1])
            temp_next = {1'b1, {(hfs_pkg::TEMP_W - 1){1'b0}}};
        else
            temp_next = {1'b0, {(hfs_pkg::TEMP_W - 1){1'b1}}};
    end

    logic signed [hfs_pkg::TEMP_W-1:0] out_temp_reg;
    logic [hfs_pkg::DIM_W-1:0]         out_row_reg, out_col_reg;
    logic                              out_done_reg;

    always_ff @(posedge clk)
    begin
        if (out_free && s3_valid_reg && s3_prod_reg)
        begin
            out_temp_reg <= temp_next;
            out_row_reg  <= s3_row_reg;
            out_col_reg  <= s3_col_reg;
            out_done_reg <= s3_done_reg;
        end
    end

    assign updates.valid     = out_valid_reg;
    assign updates.temp_out  = out_temp_reg;
    assign updates.row_index = out_row_reg;
    assign updates.col_index = out_col_reg;
    assign updates.tile_done = out_done_reg;

    // ---------------- assertions ----------------
    `HFS_ASSERT_NOW(a_index_interior,
        updates.valid,
        (updates.row_index != '0) && (updates.col_index != '0),
        "result with a ghost index")
    `HFS_ASSERT_NOW(a_done_last_cell,
        updates.valid && updates.tile_done,
        (updates.row_index == rows_eff) && (updates.col_index == cols_eff),
        "tile_done away from the last interior cell")
    `HFS_ASSERT_NEXT(a_accept_fills_stage1,
        in_fire,
        s1_valid_reg,
        "accepted word lost before the line read stage")

endmodule

>>> verif/heat_ftcs_stencil_step_tb.sv
// Self-checking testbench for the FTCS five-point heat stencil block.
// Streams padded tiles through hfs_in_if and checks every updated cell against a predictor.
// Depends on hfs_pkg, hfs_in_if, hfs_out_if and heat_ftcs_stencil_step.
`timescale 1ns / 1ps

module heat_ftcs_stencil_step_tb;

    localparam int STALL_LIMIT  = 4000;
    localparam int RAND_WORDS   = 800;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 600;
    localparam int IDLE_PCT     = 29;

    localparam logic signed [hfs_pkg::TEMP_W-1:0] TEMP_MAX =
        {1'b0, {(hfs_pkg::TEMP_W-1){1'b1}}};
    localparam logic signed [hfs_pkg::TEMP_W-1:0] TEMP_MIN =
        {1'b1, {(hfs_pkg::TEMP_W-1){1'b0}}};

    typedef struct packed {
        logic signed [hfs_pkg::TEMP_W-1:0] temp;
        logic        [hfs_pkg::DIM_W-1:0]  row;
        logic        [hfs_pkg::DIM_W-1:0]  col;
        logic                              done;
    } cell_update_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [hfs_pkg::REG_IDX_W-1:0] cfg_index;
    logic [hfs_pkg::CFG_W-1:0]     cfg_data;

    hfs_in_if  in_ch ();
    hfs_out_if out_ch ();

    heat_ftcs_stencil_step u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (in_ch),
        .updates   (out_ch)
    );

    // Register shadow
    logic        [hfs_pkg::COEF_W-1:0] coef_x_r;
    logic        [hfs_pkg::COEF_W-1:0] coef_y_r;
    logic signed [hfs_pkg::TEMP_W-1:0] bnd_temp_r;
    logic        [hfs_pkg::MASK_W-1:0] edge_mask_r;
    logic        [hfs_pkg::DIM_W-1:0]  rows_r;
    logic        [hfs_pkg::DIM_W-1:0]  cols_r;

    // Stencil state mirrored by the predictor
    logic signed [hfs_pkg::TEMP_W-1:0] line_mem [2*hfs_pkg::LINE_LEN];
    logic signed [hfs_pkg::TEMP_W-1:0] win [6];
    logic        [hfs_pkg::DIM_W-1:0]  row_cnt;
    logic        [hfs_pkg::DIM_W-1:0]  col_cnt;

    logic signed [hfs_pkg::TEMP_W-1:0] tile_words_q [$];
    cell_update_t                      update_q [$];

    int pushed_cnt;
    int taken_cnt;
    int err_cnt;
    int stall_cnt;
    int sink_hold_len;
    int src_idle_pct;
    int snk_idle_pct;
    logic in_fired;
    logic signed [hfs_pkg::TEMP_W-1:0] temp_base;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [hfs_pkg::DIM_W-1:0] eff_dim(input logic [hfs_pkg::DIM_W-1:0] raw,
                                                          input int maxv);
        if (raw == '0)
            return hfs_pkg::DIM_W'(1);
        if (raw > maxv)
            return hfs_pkg::DIM_W'(maxv);
        return raw;
    endfunction

    function automatic int tile_size();
        return (int'(eff_dim(rows_r, hfs_pkg::MAX_ROWS)) + 2) *
               (int'(eff_dim(cols_r, hfs_pkg::MAX_COLS)) + 2);
    endfunction

    function automatic logic signed [hfs_pkg::TEMP_W-1:0] ftcs_update(
        input logic signed [hfs_pkg::TEMP_W-1:0] ctr,
        input logic signed [hfs_pkg::TEMP_W-1:0] nth,
        input logic signed [hfs_pkg::TEMP_W-1:0] sth,
        input logic signed [hfs_pkg::TEMP_W-1:0] est,
        input logic signed [hfs_pkg::TEMP_W-1:0] wst
    );
        longint lap_x;
        longint lap_y;
        longint x_hi;
        longint x_lo;
        longint y_hi;
        longint y_lo;
        longint kx;
        longint ky;
        longint frac;
        longint acc;
        lap_x = longint'(nth) + longint'(sth) - 2 * longint'(ctr);
        lap_y = longint'(est) + longint'(wst) - 2 * longint'(ctr);
        // Split each Laplacian into a signed high part and a 16-bit unsigned fraction
        x_lo  = lap_x & 64'hFFFF;
        x_hi  = lap_x >>> hfs_pkg::FRAC_W;
        y_lo  = lap_y & 64'hFFFF;
        y_hi  = lap_y >>> hfs_pkg::FRAC_W;
        kx    = longint'(coef_x_r);
        ky    = longint'(coef_y_r);
        frac  = kx * x_lo + ky * y_lo + 32768;
        acc   = longint'(ctr) + kx * x_hi + ky * y_hi + (frac >>> hfs_pkg::FRAC_W);
        if (acc > longint'(TEMP_MAX))
            acc = longint'(TEMP_MAX);
        else if (acc < longint'(TEMP_MIN))
            acc = longint'(TEMP_MIN);
        return acc[hfs_pkg::TEMP_W-1:0];
    endfunction

    // Advance the stencil by one padded word; queue the update it yields, if any.
    function automatic void stencil_step(input logic signed [hfs_pkg::TEMP_W-1:0] word);
        logic        [hfs_pkg::DIM_W-1:0]  rows;
        logic        [hfs_pkg::DIM_W-1:0]  cols;
        logic        [hfs_pkg::DIM_W-1:0]  r;
        logic        [hfs_pkg::DIM_W-1:0]  c;
        logic signed [hfs_pkg::TEMP_W-1:0] v;
        logic signed [hfs_pkg::TEMP_W-1:0] cs;
        logic signed [hfs_pkg::TEMP_W-1:0] cm;
        int                                old_base;
        int                                mid_base;
        cell_update_t                      upd;
        rows = eff_dim(rows_r, hfs_pkg::MAX_ROWS);
        cols = eff_dim(cols_r, hfs_pkg::MAX_COLS);
        r    = row_cnt;
        c    = col_cnt;
        v    = word;
        if (r > rows + 1)
            r = hfs_pkg::DIM_W'(rows + 1);
        if (c > cols + 1)
            c = hfs_pkg::DIM_W'(cols + 1);
        if ((r == 0 && edge_mask_r[hfs_pkg::EDGE_SOUTH]) ||
            (r == rows + 1 && edge_mask_r[hfs_pkg::EDGE_NORTH]) ||
            (c == 0 && edge_mask_r[hfs_pkg::EDGE_WEST]) ||
            (c == cols + 1 && edge_mask_r[hfs_pkg::EDGE_EAST]))
            v = bnd_temp_r;

        old_base = r[0] ? hfs_pkg::LINE_LEN : 0;
        mid_base = r[0] ? 0 : hfs_pkg::LINE_LEN;
        cs = line_mem[old_base + c];
        cm = line_mem[mid_base + c];
        line_mem[old_base + c] = v;

        if (r >= 2 && c >= 2)
        begin
            upd.temp = ftcs_update(win[1], win[2], win[0], cm, win[4]);
            upd.row  = hfs_pkg::DIM_W'(r - 1);
            upd.col  = hfs_pkg::DIM_W'(c - 1);
            upd.done = (r == rows + 1) && (c == cols + 1);
            update_q.push_back(upd);
        end

        win[3] = win[0];
        win[4] = win[1];
        win[5] = win[2];
        win[0] = cs;
        win[1] = cm;
        win[2] = v;

        if (c >= cols + 1)
        begin
            col_cnt = '0;
            row_cnt = (r >= rows + 1) ? '0 : hfs_pkg::DIM_W'(r + 1);
        end
        else
        begin
            col_cnt = hfs_pkg::DIM_W'(c + 1);
            row_cnt = r;
        end
    endfunction

    function automatic logic signed [hfs_pkg::TEMP_W-1:0] pick_temp();
        int sel;
        sel = $urandom_range(99);
        if (sel < 20)
            return $urandom;
        if (sel < 26)
        begin
            case ($urandom_range(3))
                0:       return TEMP_MAX;
                1:       return TEMP_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        return hfs_pkg::TEMP_W'(temp_base + $signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endfunction

    function automatic logic [hfs_pkg::COEF_W-1:0] pick_coef();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15)
            return '0;
        if (sel < 30)
            return '1;
        if (sel < 70)
            return hfs_pkg::COEF_W'($urandom_range(0, 16384));
        return hfs_pkg::COEF_W'($urandom);
    endfunction

    function automatic logic signed [hfs_pkg::TEMP_W-1:0] pick_boundary();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15)
            return TEMP_MAX;
        if (sel < 30)
            return TEMP_MIN;
        if (sel < 65)
            return hfs_pkg::TEMP_W'(temp_base + $signed($urandom_range(0, 1 << 20)) - (1 << 19));
        return $urandom;
    endfunction

    function automatic void report_field(input string field, input logic signed [63:0] want_v,
                                         input logic signed [63:0] got_v);
        err_cnt++;
        $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
    endfunction

    task automatic write_reg(input hfs_pkg::hfs_reg_t idx, input logic [hfs_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            hfs_pkg::REG_COEF_X:    coef_x_r    = val[hfs_pkg::COEF_W-1:0];
            hfs_pkg::REG_COEF_Y:    coef_y_r    = val[hfs_pkg::COEF_W-1:0];
            hfs_pkg::REG_BND_TEMP:  bnd_temp_r  = val[hfs_pkg::TEMP_W-1:0];
            hfs_pkg::REG_EDGE_MASK: edge_mask_r = val[hfs_pkg::MASK_W-1:0];
            hfs_pkg::REG_ROWS:      rows_r      = val[hfs_pkg::DIM_W-1:0];
            hfs_pkg::REG_COLS:      cols_r      = val[hfs_pkg::DIM_W-1:0];
            default: ;
        endcase
    endtask

    // Drop the write enable, then land on a rising edge so pushes never meet a write.
    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_tile(input logic        [hfs_pkg::COEF_W-1:0] cx,
                            input logic        [hfs_pkg::COEF_W-1:0] cy,
                            input logic signed [hfs_pkg::TEMP_W-1:0] bnd,
                            input logic        [hfs_pkg::MASK_W-1:0] mask,
                            input logic        [hfs_pkg::DIM_W-1:0]  rows,
                            input logic        [hfs_pkg::DIM_W-1:0]  cols);
        write_reg(hfs_pkg::REG_COEF_X, hfs_pkg::CFG_W'(cx));
        write_reg(hfs_pkg::REG_COEF_Y, hfs_pkg::CFG_W'(cy));
        write_reg(hfs_pkg::REG_BND_TEMP, hfs_pkg::CFG_W'(bnd));
        write_reg(hfs_pkg::REG_EDGE_MASK, hfs_pkg::CFG_W'(mask));
        write_reg(hfs_pkg::REG_ROWS, hfs_pkg::CFG_W'(rows));
        write_reg(hfs_pkg::REG_COLS, hfs_pkg::CFG_W'(cols));
        end_writes();
    endtask

    task automatic push_word(input logic signed [hfs_pkg::TEMP_W-1:0] v);
        tile_words_q.push_back(v);
        pushed_cnt++;
    endtask

    task automatic push_random(input int n);
        repeat (n) push_word(pick_temp());
    endtask

    // Hold until every word is in and every update is out, then let the pipe empty.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (taken_cnt != pushed_cnt || update_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        in_fired = rst_n && in_ch.valid && in_ch.ready;
        if (in_fired)
        begin
            stencil_step(in_ch.temp_in);
            taken_cnt++;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_fired)
        begin
            if (tile_words_q.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                in_ch.valid   <= 1'b1;
                in_ch.temp_in <= tile_words_q.pop_front();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (sink_hold_len > 0)
        begin
            out_ch.ready <= 1'b0;
            sink_hold_len--;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin : update_check
        cell_update_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (update_q.size() == 0)
            begin
                err_cnt++;
                $display("[%0t] update mismatch: expected none, actual row %0d col %0d temp %0d",
                         $time, out_ch.row_index, out_ch.col_index, out_ch.temp_out);
            end
            else
            begin
                want = update_q.pop_front();
                if (out_ch.temp_out !== want.temp)
                    report_field("temp_out", 64'(want.temp), 64'(out_ch.temp_out));
                if (out_ch.row_index !== want.row)
                    report_field("row_index", 64'(want.row), 64'(out_ch.row_index));
                if (out_ch.col_index !== want.col)
                    report_field("col_index", 64'(want.col), 64'(out_ch.col_index));
                if (out_ch.tile_done !== want.done)
                    report_field("tile_done", 64'(want.done), 64'(out_ch.tile_done));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("heat_ftcs_stencil_step regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                          total;
        int                          cut;
        int                          left;
        int                          rand_words;
        logic [hfs_pkg::DIM_W-1:0]   rows_eff;
        logic [hfs_pkg::DIM_W-1:0]   cols_eff;
        logic [hfs_pkg::DIM_W-1:0]   r_at;
        logic [hfs_pkg::DIM_W-1:0]   c_at;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.temp_in = '0;
        out_ch.ready  = 1'b0;
        coef_x_r      = '0;
        coef_y_r      = '0;
        bnd_temp_r    = '0;
        edge_mask_r   = 4'hF;
        rows_r        = hfs_pkg::DIM_W'(hfs_pkg::MAX_ROWS);
        cols_r        = hfs_pkg::DIM_W'(hfs_pkg::MAX_COLS);
        foreach (line_mem[i])
            line_mem[i] = '0;
        foreach (win[i])
            win[i] = '0;
        row_cnt       = '0;
        col_cnt       = '0;
        pushed_cnt    = 0;
        taken_cnt     = 0;
        err_cnt       = 0;
        stall_cnt     = 0;
        sink_hold_len = 0;
        src_idle_pct  = IDLE_PCT;
        snk_idle_pct  = IDLE_PCT;
        temp_base     = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // 1x1 tile, rows written as zero, no marked edges, full-scale coefficients:
        // saturate upward, then downward; corners hold values that must not matter.
        set_tile('1, '1, '0, 4'h0, '0, hfs_pkg::DIM_W'(1));
        push_word('0);      push_word(TEMP_MAX); push_word('0);
        push_word(TEMP_MAX); push_word(TEMP_MIN); push_word(TEMP_MAX);
        push_word('0);      push_word(TEMP_MAX); push_word('0);
        push_word('1);      push_word(TEMP_MIN); push_word('1);
        push_word(TEMP_MIN); push_word(TEMP_MAX); push_word(TEMP_MIN);
        push_word('1);      push_word(TEMP_MIN); push_word('1);

        // All edges marked: every ghost word is forced to the boundary temperature
        wait_quiet();
        set_tile('0, 16'h8000, TEMP_MAX, 4'hF, hfs_pkg::DIM_W'(1), hfs_pkg::DIM_W'(1));
        push_random(9);

        // Tall tile, columns written as zero; no idling
        wait_quiet();
        temp_base = $signed($urandom_range(0, 200 << 16)) - (100 << 16);
        set_tile(pick_coef(), pick_coef(), pick_boundary(),
                 hfs_pkg::MASK_W'($urandom_range(15)), hfs_pkg::DIM_W'(100), '0);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        push_random(tile_size());
        wait_quiet();
        src_idle_pct = IDLE_PCT;
        snk_idle_pct = IDLE_PCT;

        // Wide tile; the sink holds off long enough to back up the input
        set_tile(pick_coef(), pick_coef(), pick_boundary(),
                 hfs_pkg::MASK_W'($urandom_range(15)), '0, hfs_pkg::DIM_W'(100));
        sink_hold_len = HOLD_CYCLES;
        push_random(tile_size());

        rand_words = 0;
        while (rand_words < RAND_WORDS)
        begin
            if (rand_words == 0 || $urandom_range(99) >= 35)
            begin
                wait_quiet();
                temp_base = $signed($urandom_range(0, 200 << 16)) - (100 << 16);
                set_tile(pick_coef(), pick_coef(), pick_boundary(),
                         hfs_pkg::MASK_W'($urandom_range(15)),
                         hfs_pkg::DIM_W'($urandom_range(1, 6)),
                         hfs_pkg::DIM_W'($urandom_range(1, 8)));
                if ($urandom_range(99) < 20)
                begin
                    // Change the geometry in mid-tile, then finish the tile as it now stands.
                    // Columns never grow so no row reads a column it never wrote.
                    total = tile_size();
                    cut   = $urandom_range(1, total - 1);
                    push_random(cut);
                    rand_words += cut;
                    wait_quiet();
                    if ($urandom_range(1) == 1)
                        write_reg(hfs_pkg::REG_ROWS, $urandom_range(1, 6));
                    else
                        write_reg(hfs_pkg::REG_COLS,
                                  $urandom_range(1, int'(eff_dim(cols_r, hfs_pkg::MAX_COLS))));
                    end_writes();
                    rows_eff = eff_dim(rows_r, hfs_pkg::MAX_ROWS);
                    cols_eff = eff_dim(cols_r, hfs_pkg::MAX_COLS);
                    r_at = (row_cnt > rows_eff + 1) ? hfs_pkg::DIM_W'(rows_eff + 1) : row_cnt;
                    c_at = (col_cnt > cols_eff + 1) ? hfs_pkg::DIM_W'(cols_eff + 1) : col_cnt;
                    left = (int'(rows_eff) + 1 - int'(r_at)) * (int'(cols_eff) + 2)
                         + (int'(cols_eff) + 2 - int'(c_at));
                    push_random(left);
                    rand_words += left;
                end
                else
                begin
                    total = tile_size();
                    push_random(total);
                    rand_words += total;
                end
            end
            else
            begin
                // Same settings, next tile back to back
                total = tile_size();
                push_random(total);
                rand_words += total;
            end
        end

        wait_quiet();
        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("heat_ftcs_stencil_step regression: pass");
        else
            $display("heat_ftcs_stencil_step regression: fail");
        $finish;
    end

endmodule
